### rtl/vtns_pkg.sv
// Shared types, field widths and codes for the vertex table search block.
`timescale 1ns / 1ps

package vtns_pkg;

   localparam int MAX_VERTICES_DEF = 1024;

   localparam int COORD_W    = 20;
   localparam int ACTION_W   = 2;
   localparam int VIDX_W     = 10;
   localparam int AXIS_W     = 2;
   localparam int FOUND_W    = 10;
   localparam int MOVED_W    = 11;
   localparam int COUNT_W    = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // abs difference, its square, and the sum of three squares
   localparam int MAG_W  = 20;
   localparam int PROD_W = 40;
   localparam int DIST_W = 42;

   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_NEAREST = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SHIFT   = 2'd2;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // register select bit (paddr[2]) for the vertex count register
   localparam logic CSR_REG_VERTEX_COUNT = 1'b0;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vertex_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VIDX_W-1:0]   vertex_index;
      coord_type           coord_x;
      coord_type           coord_y;
      coord_type           coord_z;
      logic [AXIS_W-1:0]   axis;
      coord_type           delta;
   } req_type;

   typedef struct packed {
      logic [FOUND_W-1:0] found_index;
      logic [MOVED_W-1:0] moved_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL_LOAD,
      ST_FETCH,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_CMP,
      ST_CHECK,
      ST_DONE
   } st_type;

endpackage

### rtl/vtns_vertex_mem.sv
// Vertex position memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module vtns_vertex_mem #(
   parameter int DEPTH  = vtns_pkg::MAX_VERTICES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  vtns_pkg::vertex_type wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output vtns_pkg::vertex_type rd_data
);
   import vtns_pkg::*;

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vertex_table_nearest_and_shift.sv
// Top level of the vertex table with nearest-vertex search and coincident shift.
`timescale 1ns / 1ps

// Holds up to MAX_VERTICES 3D positions (Q15.4, 20 bits per axis) in one
// single-read, single-write memory and serves one item at a time. A write
// item stores an in-range entry at accept and goes through ST_DONE.
// A nearest item walks entries 0 .. min(vertex_count, MAX_VERTICES)-1
// through one shared subtract / square / accumulate unit, one axis at a
// time, with three passes of the squaring multiplier per entry. The first
// entry with the smallest squared distance wins; an empty table returns
// index 0. A shift item reads the selected entry first, then walks the
// entries in use, moving every exact match of it along the chosen axis
// with saturation. req_stall is high in reset and while an item is in
// work; a finished result sits in the output register until taken, so the
// next item is accepted while it waits. The memory has no reset: reading
// an entry never written gives an undefined position. Write vertex_count
// (byte address 0) only while the block is idle.
module vertex_table_nearest_and_shift #(
   parameter int MAX_VERTICES = vtns_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vtns_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vtns_pkg::rsp_type                   rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vtns_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [vtns_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [vtns_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import vtns_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [31:0] MAX_V32 = 32'(MAX_VERTICES);

   function automatic coord_type coord_of(input vertex_type v, input logic [AXIS_W-1:0] sel);
      case (sel)
         AXIS_X:  coord_of = v.x;
         AXIS_Y:  coord_of = v.y;
         default: coord_of = v.z;
      endcase
   endfunction

   // control state
   st_type             st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] vertex_count_ff;

   // item payload and scan datapath
   req_type            req_ff, req_in;
   rsp_type            rsp_item_ff, rsp_item_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [AXIS_W-1:0]  ax_ff, ax_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIST_W-1:0]  acc_ff, acc_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   found_ff, found_in;
   logic [CNT_W-1:0]   moved_ff, moved_in;
   vertex_type         old_ff, old_in;

   // memory port
   logic               mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
   vertex_type         mem_wr_data, mem_rd_data;

   logic               accept, idx_ok, axis_ok, last, can_load, csr_wr, match;
   logic [31:0]        count32;
   logic [CNT_W-1:0]   scan_len;
   vertex_type         ref_v, new_v, req_v;
   coord_type          cur_c, ref_c, sh_c, sat_c;
   logic signed [COORD_W:0] diff, sum;
   logic [COORD_W:0]   diff_abs;
   logic [PROD_W-1:0]  prod;

   assign accept   = req_valid && !req_stall;
   assign req_stall = reset || (st_ff != ST_IDLE);
   assign can_load = !rsp_valid_ff || !rsp_stall;

   // scan length saturates at the table depth
   assign count32  = 32'(vertex_count_ff);
   assign scan_len = (count32 > MAX_V32) ? CNT_W'(MAX_V32) : CNT_W'(count32);
   assign idx_ok   = 32'(req_item.vertex_index) < MAX_V32;
   assign axis_ok  = (req_item.axis == AXIS_X) || (req_item.axis == AXIS_Y) ||
                     (req_item.axis == AXIS_Z);
   assign last     = (idx_ff + CNT_W'(1)) == len_ff;

   assign req_v.x = req_item.coord_x;
   assign req_v.y = req_item.coord_y;
   assign req_v.z = req_item.coord_z;
   assign ref_v.x = req_ff.coord_x;
   assign ref_v.y = req_ff.coord_y;
   assign ref_v.z = req_ff.coord_z;

   // shared distance unit: one axis difference, then its square
   assign cur_c    = coord_of(mem_rd_data, ax_ff);
   assign ref_c    = coord_of(ref_v, ax_ff);
   assign diff     = {cur_c[COORD_W-1], cur_c} - {ref_c[COORD_W-1], ref_c};
   assign diff_abs = diff[COORD_W] ? (~diff + 1'b1) : diff;
   assign prod     = mag_ff * mag_ff;

   // shift unit: exact match on all three axes, saturating add on one
   assign match = (mem_rd_data == old_ff);
   assign sh_c  = coord_of(mem_rd_data, req_ff.axis);
   assign sum   = {sh_c[COORD_W-1], sh_c} + {req_ff.delta[COORD_W-1], req_ff.delta};
   assign sat_c = (sum[COORD_W] != sum[COORD_W-1]) ?
                  (sum[COORD_W] ? COORD_MIN : COORD_MAX) : sum[COORD_W-1:0];

   always_comb begin
      new_v = mem_rd_data;
      case (req_ff.axis)
         AXIS_X:  new_v.x = sat_c;
         AXIS_Y:  new_v.y = sat_c;
         default: new_v.z = sat_c;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  ACT_NEAREST: st_in = (scan_len == '0) ? ST_DONE : ST_DIFF;
                  ACT_SHIFT: begin
                     if (axis_ok && idx_ok && (scan_len != '0)) begin
                        st_in = ST_SEL_LOAD;
                     end else begin
                        st_in = ST_DONE;
                     end
                  end
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_SEL_LOAD: st_in = ST_FETCH;
         ST_FETCH:    st_in = (req_ff.action == ACT_NEAREST) ? ST_DIFF : ST_CHECK;
         ST_DIFF:     st_in = ST_MUL;
         ST_MUL:      st_in = ST_ACC;
         ST_ACC:      st_in = (ax_ff == AXIS_Z) ? ST_CMP : ST_DIFF;
         ST_CMP:      st_in = last ? ST_DONE : ST_FETCH;
         ST_CHECK:    st_in = last ? ST_DONE : ST_FETCH;
         ST_DONE:     st_in = can_load ? ST_IDLE : ST_DONE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // datapath, memory port and result register
   always_comb begin
      req_in       = req_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      ax_in        = ax_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      moved_in     = moved_ff;
      old_in       = old_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff[IDX_W-1:0];
      mem_wr_data  = new_v;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               len_in   = scan_len;
               idx_in   = '0;
               ax_in    = AXIS_X;
               acc_in   = '0;
               found_in = '0;
               moved_in = '0;
               case (req_item.action)
                  ACT_WRITE: begin
                     mem_wr_en   = idx_ok;
                     mem_wr_addr = IDX_W'(req_item.vertex_index);
                     mem_wr_data = req_v;
                  end
                  ACT_NEAREST: begin
                     // fetch entry 0 now, it is ready in the first diff cycle
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                  end
                  ACT_SHIFT: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = IDX_W'(req_item.vertex_index);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEL_LOAD: old_in = mem_rd_data;
         ST_FETCH: begin
            mem_rd_en = 1'b1;
            ax_in     = AXIS_X;
            acc_in    = '0;
         end
         ST_DIFF: mag_in = diff_abs[MAG_W-1:0];
         ST_MUL:  prod_in = prod;
         ST_ACC: begin
            acc_in = acc_ff + DIST_W'(prod_ff);
            if (ax_ff != AXIS_Z) begin
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_CMP: begin
            // strict compare keeps the lowest index among ties
            if ((idx_ff == '0) || (acc_ff < best_ff)) begin
               best_in  = acc_ff;
               found_in = idx_ff[IDX_W-1:0];
            end
            if (!last) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_CHECK: begin
            if (match) begin
               mem_wr_en = 1'b1;
               moved_in  = moved_ff + CNT_W'(1);
            end
            if (!last) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.found_index = FOUND_W'(found_ff);
               rsp_item_in.moved_count = MOVED_W'(moved_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign csr_wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == CSR_REG_VERTEX_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            vertex_count_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      ax_ff       <= ax_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      moved_ff    <= moved_in;
      old_ff      <= old_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_REG_VERTEX_COUNT) ?
                      CSR_DATA_W'(vertex_count_ff) : '0;

   vtns_vertex_mem #(
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // scan index stays inside the scan length while walking entries
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FETCH || st_ff == ST_DIFF || st_ff == ST_MUL || st_ff == ST_ACC ||
       st_ff == ST_CMP || st_ff == ST_CHECK) |-> (idx_ff < len_ff))
      else $error("scan index beyond scan length");

   // the distance unit only ever works on a real axis
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIFF || st_ff == ST_MUL || st_ff == ST_ACC) |-> (ax_ff <= AXIS_Z))
      else $error("distance unit axis out of range");

   // cannot move more entries than have been visited
   a_moved_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHECK) |-> (moved_ff <= idx_ff))
      else $error("moved count ahead of scan index");

   // memory is written only by a write item at accept or by a shift match
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((st_ff == ST_IDLE && req_item.action == ACT_WRITE) ||
                     (st_ff == ST_CHECK && req_ff.action == ACT_SHIFT)))
      else $error("unexpected memory write");

   // only a nearest item reports a nonzero index
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE && req_ff.action != ACT_NEAREST) |-> (found_ff == '0))
      else $error("found index set by a non-query item");

endmodule
